[rtl/aodv_pkg.sv]
// Package for the AODV route table engine: operation codes, widths, item types.
// No dependencies.
`default_nettype none
package aodv_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [2:0] OpUpdate     = 3'd0;
  localparam logic [2:0] OpLookup     = 3'd1;
  localparam logic [2:0] OpInvalidate = 3'd2;
  localparam logic [2:0] OpFresh      = 3'd3;
  localparam logic [2:0] OpRouteError = 3'd4;

  // Decoded request passed from front to back.
  typedef struct packed {
    logic       is_update;
    logic       is_invalidate;
    logic       is_fresh;
    logic       is_route_error;
    logic [7:0] destination;
    logic [7:0] via_node;
    logic [7:0] hops;
    logic [7:0] sequence_req;
    logic       valid;
  } req_t;
endpackage
`default_nettype wire

[rtl/aodv_front.sv]
// Front end: accepts input items, decodes the operation, two-entry request queue.
// Depends on aodv_pkg.
`default_nettype none
module aodv_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire logic [39:0]        s_tdata_i,
  output logic                    req_valid_o,
  input  wire logic               req_ready_i,
  output aodv_pkg::req_t          req_o
);
  import aodv_pkg::*;

  req_t       buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  req_t       dec;
  logic [2:0] op;
  logic       push, pop;

  // Decode the incoming item
  always_comb begin
    op                 = s_tdata_i[2:0];
    dec.is_update      = (op == OpUpdate);
    dec.is_invalidate  = (op == OpInvalidate);
    dec.is_fresh       = (op == OpFresh);
    dec.is_route_error = (op == OpRouteError);
    dec.destination    = s_tdata_i[10:3];
    dec.via_node       = s_tdata_i[18:11];
    dec.hops           = s_tdata_i[26:19];
    dec.sequence_req   = s_tdata_i[34:27];
    dec.valid          = s_tdata_i[35];
  end

  assign s_tready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_q];
  assign push        = s_tvalid_i && s_tready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= dec;
    end
  end
endmodule
`default_nettype wire

[rtl/aodv_back.sv]
// Back end: scans the table one entry a cycle, applies the operation, holds result.
// Depends on aodv_pkg.
`default_nettype none
module aodv_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  aodv_pkg::req_t   req_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [23:0]      m_tdata_o
);
  import aodv_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StExec = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]        st_q, st_d;
  logic [TableEntries-1:0] used_q;
  logic [7:0]        dst_mem [TableEntries];
  logic [7:0]        nh_mem  [TableEntries];
  logic [7:0]        hop_mem [TableEntries];
  logic [7:0]        seq_mem [TableEntries];
  logic              val_mem [TableEntries];

  req_t              req_q;
  logic [CntW-1:0]   scan_q;
  logic              hit_q, free_ok_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q;
  logic [23:0]       res_q;
  logic [IdxW-1:0]   si;

  assign si          = scan_q[IdxW-1:0];
  assign req_ready_o = (st_q == StIdle);
  assign m_tvalid_o  = (st_q == StOut);
  assign m_tdata_o   = res_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (req_valid_i) st_d = StScan;
      StScan: if (scan_q == CntW'(TableEntries - 1) || (used_q[si] && dst_mem[si] ==
                  req_q.destination)) st_d = StExec;
      StExec: st_d = StOut;
      StOut:  if (m_tready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      used_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StExec && req_q.is_update && !hit_q && free_ok_q) begin
        used_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Scan, then execute on the found or allocated entry
  always_ff @(posedge clk_i) begin
    logic [IdxW-1:0] ix;
    logic            have, apply;
    logic [7:0]      s, nh;
    logic            v;
    case (st_q)
      StIdle: begin
        req_q     <= req_i;
        scan_q    <= '0;
        hit_q     <= 1'b0;
        free_ok_q <= 1'b0;
        free_idx_q <= '0;
      end
      StScan: begin
        scan_q <= scan_q + 1'b1;
        if (used_q[si] && dst_mem[si] == req_q.destination) begin
          hit_q     <= 1'b1;
          hit_idx_q <= si;
        end
        if (!used_q[si] && !free_ok_q) begin
          free_ok_q  <= 1'b1;
          free_idx_q <= si;
        end
      end
      StExec: begin
        ix    = hit_q ? hit_idx_q : free_idx_q;
        have  = hit_q || (req_q.is_update && free_ok_q);
        apply = 1'b0;
        s     = seq_mem[ix];
        nh    = nh_mem[ix];
        v     = val_mem[ix];
        if (req_q.is_update) begin
          apply = !hit_q ? free_ok_q :
                  (s < req_q.sequence_req ||
                   (s == req_q.sequence_req && hop_mem[ix] > req_q.hops));
          if (apply) begin
            s = req_q.sequence_req; nh = req_q.via_node; v = req_q.valid;
            dst_mem[ix] <= req_q.destination;
            nh_mem[ix]  <= req_q.via_node;
            hop_mem[ix] <= req_q.hops;
          end
        end else if (hit_q && (req_q.is_invalidate || req_q.is_route_error)) begin
          v = 1'b0;
          if (req_q.is_route_error) s = s + 8'd1;
        end
        seq_mem[ix] <= s;
        val_mem[ix] <= v;
        // fields low to high: next hop out, entry_found, route_fresh,
        // update_applied, table_full, sequence_out
        res_q <= {4'd0, have ? s : 8'd0,
                  req_q.is_update && !hit_q && !free_ok_q,
                  apply,
                  req_q.is_fresh && hit_q && v && (s >= req_q.sequence_req),
                  have,
                  (have && v) ? nh : 8'd0};
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/aodv_route_table_engine.sv]
// Top level of the AODV route table engine: front decoder/queue plus table back end.
// Depends on aodv_pkg, aodv_front, aodv_back.
// Each item passes through the front queue, then the back-end states Idle, Scan, Exec and
// Out; Scan stops at the matching entry, or after all TableEntries entries on a miss or new key.
// The back end handles one item at a time; the front queue holds two items meanwhile.
// Reset: asynchronous, active low; clears the entry-used bits, the back-end state and the front queue pointers.
`default_nettype none
module aodv_route_table_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[2:0], destination[10:3], offered_next_hop[18:11], offered_hops[26:19],
  // sequence_req[34:27], offered_valid[35], zero fill
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_hop_out[7:0], entry_found[8], route_fresh[9], update_applied[10],
  // table_full[11], sequence_out[19:12], zero fill
  output logic [23:0]      m_axis_tdata
);
  import aodv_pkg::*;

  logic req_valid, req_ready;
  req_t req;

  aodv_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_axis_tvalid), .s_tready_o (s_axis_tready), .s_tdata_i (s_axis_tdata),
    .req_valid_o (req_valid), .req_ready_i (req_ready), .req_o (req)
  );

  aodv_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i (req_valid), .req_ready_o (req_ready), .req_i (req),
    .m_tvalid_o (m_axis_tvalid), .m_tready_i (m_axis_tready), .m_tdata_o (m_axis_tdata)
  );
endmodule
`default_nettype wire

[rtl/aodv_checker.sv]
// Port-level checker for the route table engine, bound to the top level.
// No dependencies.
`default_nettype none
module aodv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // absent entry reports zero next hop and sequence
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0 &&
    m_axis_tdata[19:12] == 8'd0) else $error("absent entry with data");
  // full table never coincides with found or applied
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> !m_axis_tdata[8] && !m_axis_tdata[10])
    else $error("full flag inconsistent");
  // at most one of fresh, applied, full
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[11:9])) else $error("flags overlap");
endmodule

bind aodv_route_table_engine aodv_checker u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
